// File: rtl/core/rmst_pkg.sv
// Shared constants and codes for the reference-count mark/sweep table.
package rmst_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int HANDLE_BITS = 32;

  // Width of the port fields.
  localparam int PORT_HANDLE_W = 32;

  // Handles are held at the narrower of the handle width and the port width.
  localparam int HANDLE_W = (HANDLE_BITS < PORT_HANDLE_W) ? HANDLE_BITS : PORT_HANDLE_W;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Command codes.
  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_FORGET_ALL = 2'd1;
  localparam logic [1:0] CMD_CLEAN      = 2'd2;
  localparam logic [1:0] CMD_CLEAN_ALL  = 2'd3;

  // Entry status codes.
  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_KNOWN   = 2'd1;
  localparam logic [1:0] ST_FORGET  = 2'd2;

  // Result action codes.
  localparam logic [1:0] ACT_INC = 2'd0;
  localparam logic [1:0] ACT_DEC = 2'd1;
  localparam logic [1:0] ACT_OVF = 2'd2;

endpackage

// File: rtl/core/rmst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/refcount_mark_sweep_table.sv
// Reference-count mark/sweep table: top level with scan sequencer and handle RAM.
// Register and sweep commands scan the used entries through the single read port of the
// handle RAM, stepping through the READ and CHECK states for each used entry. A register
// stops early on a hit and otherwise ends in RESOLVE; both commands wait while the output
// word is held. forget_all completes without leaving the idle state.
// Reset clears statuses and the used count but not the handle RAM; ready right after reset.
module refcount_mark_sweep_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_cmd,
  input  logic [rmst_pkg::PORT_HANDLE_W-1:0] in_handle_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_action,
  output logic [rmst_pkg::PORT_HANDLE_W-1:0] out_target_handle,
  output logic                              out_last
);

  import rmst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_READ    = 4'b0010,
    S_CHECK   = 4'b0100,
    S_RESOLVE = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           cmd_r, cmd_nxt;
  logic [HANDLE_W-1:0]  h_r, h_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     free_r, free_nxt;
  logic [1:0]           stat_r [TABLE_DEPTH];
  logic [1:0]           stat_nxt [TABLE_DEPTH];

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_action_r, out_action_nxt;
  logic [PORT_HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [HANDLE_W-1:0]  ram_rdata;

  logic                 out_stall;
  logic [TABLE_DEPTH-1:0] qual_v;
  logic [TABLE_DEPTH-1:0] stale_v;
  logic                 any_later;
  logic [1:0]           cur_stat;
  logic                 cur_live;
  logic [IDX_W-1:0]     cur_idx;

  // Handle storage, read at the scan index.
  rmst_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_handle_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (h_r),
    .raddr (cur_idx),
    .rdata (ram_rdata)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_target_handle = out_handle_r;
  assign out_last          = out_last_r;

  assign out_stall = out_valid_r && !out_ready;
  assign cur_idx   = i_r[IDX_W-1:0];
  assign cur_stat  = stat_r[cur_idx];
  assign cur_live  = (cur_stat == ST_KNOWN) || (cur_stat == ST_FORGET);

  // Entries a sweep will free, and whether any lies beyond the current index.
  always_comb begin
    any_later = 1'b0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      qual_v[j] = (CNT_W'(j) < used_r) &&
                  ((stat_r[j] == ST_FORGET) ||
                   ((cmd_r == CMD_CLEAN_ALL) && (stat_r[j] == ST_KNOWN)));
      stale_v[j] = (CNT_W'(j) >= used_r) && (stat_r[j] != ST_UNKNOWN);
      if (qual_v[j] && (CNT_W'(j) > i_r)) begin
        any_later = 1'b1;
      end
    end
  end

  // Command sequencer.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    h_nxt          = h_r;
    i_nxt          = i_r;
    used_nxt       = used_r;
    found_nxt      = found_r;
    free_nxt       = free_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_action_nxt = out_action_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = free_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          h_nxt     = in_handle_id[HANDLE_W-1:0];
          i_nxt     = '0;
          found_nxt = 1'b0;
          if (in_cmd == CMD_FORGET_ALL) begin
            // Mark every known entry in one step.
            for (int j = 0; j < TABLE_DEPTH; j++) begin
              if (stat_r[j] == ST_KNOWN) begin
                stat_nxt[j] = ST_FORGET;
              end
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        // The RAM read for the current index is issued in this cycle.
        if (i_r == used_r) begin
          state_nxt = (cmd_r == CMD_REGISTER) ? S_RESOLVE : S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (cmd_r == CMD_REGISTER) begin
          if (cur_live && (ram_rdata == h_r)) begin
            // Already held: revive a forget entry and finish without a word.
            stat_nxt[cur_idx] = ST_KNOWN;
            state_nxt         = S_IDLE;
          end else begin
            if (!cur_live) begin
              found_nxt = 1'b1;
              free_nxt  = cur_idx;
            end
            i_nxt     = i_r + 1'b1;
            state_nxt = S_READ;
          end
        end else if (qual_v[cur_idx]) begin
          // Free this entry once the output register can take the word.
          if (!out_stall) begin
            out_valid_nxt     = 1'b1;
            out_action_nxt    = ACT_DEC;
            out_handle_nxt    = PORT_HANDLE_W'(ram_rdata);
            out_last_nxt      = !any_later;
            stat_nxt[cur_idx] = ST_UNKNOWN;
            i_nxt             = i_r + 1'b1;
            state_nxt         = S_READ;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_READ;
        end
      end

      S_RESOLVE: begin
        // Claim a slot for the new handle, or report a full table.
        if (!out_stall) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = PORT_HANDLE_W'(h_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
          if (!found_r && (used_r == CNT_W'(TABLE_DEPTH))) begin
            out_action_nxt = ACT_OVF;
          end else begin
            out_action_nxt = ACT_INC;
            ram_we         = 1'b1;
            if (found_r) begin
              ram_waddr = free_r;
            end else begin
              ram_waddr = used_r[IDX_W-1:0];
              used_nxt  = used_r + 1'b1;
            end
            stat_nxt[ram_waddr] = ST_KNOWN;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        stat_r[j] <= ST_UNKNOWN;
      end
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      stat_r      <= stat_nxt;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    h_r          <= h_nxt;
    i_r          <= i_nxt;
    found_r      <= found_nxt;
    free_r       <= free_nxt;
    out_action_r <= out_action_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  // An overflow word is only produced when every slot is in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_action_r == ACT_OVF)) |-> (used_r == CNT_W'(TABLE_DEPTH)))
    else $error("overflow reported with free slots");

  // Entries at or beyond the used count always stay unknown.
  assert property (@(posedge clk) disable iff (!rst_n) stale_v == '0)
    else $error("entry beyond used count is live");

  // The scan index never runs past the used count while a scan is active.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_READ) || (state_r == S_CHECK)) |-> (i_r <= used_r))
    else $error("scan index past used count");

endmodule
